// File: rtl/xdl_pkg.sv
// ----------------------------------------------------------------------------
// XOR distance shortlist package
// Shared codes, field widths and the command and status bundles that run
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package xdl_pkg;

    // Fixed field widths of the interface
    localparam int KEY_W  = 64;
    localparam int EP_W   = 48;
    localparam int CMD_W  = 3;
    localparam int MAXC_W = 6;
    localparam int ATT_W  = 4;
    localparam int PH_W   = 2;
    localparam int CODE_W = 2;
    localparam int CFGI_W = 2;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_ADD       = 3'd0;
    localparam logic [CMD_W-1:0] CMD_MARK_RESP = 3'd1;
    localparam logic [CMD_W-1:0] CMD_MARK_TO   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SEL_NEW   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SEL_RESP  = 3'd4;

    // Peer phases
    localparam logic [PH_W-1:0] PH_UNKNOWN   = 2'd0;
    localparam logic [PH_W-1:0] PH_CONTACTED = 2'd1;
    localparam logic [PH_W-1:0] PH_RESPONDED = 2'd2;
    localparam logic [PH_W-1:0] PH_TIMEDOUT  = 2'd3;

    // Status codes
    localparam logic [CODE_W-1:0] ST_OK        = 2'd0;
    localparam logic [CODE_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [CODE_W-1:0] ST_DUP       = 2'd2;
    localparam logic [CODE_W-1:0] ST_FULL      = 2'd3;

    // Configuration register indexes
    localparam logic [CFGI_W-1:0] CFG_TARGET  = 2'd0;
    localparam logic [CFGI_W-1:0] CFG_SELF    = 2'd1;
    localparam logic [CFGI_W-1:0] CFG_MAX_ATT = 2'd2;

    localparam logic [ATT_W-1:0] ATT_MAX       = 4'd15;
    localparam logic [ATT_W-1:0] ATT_RESET_VAL = 4'd3;

    // Kinds of table write
    typedef enum logic [2:0] {
        WR_NONE,
        WR_INSERT,
        WR_SHIFT,
        WR_RESP,
        WR_TIMEOUT,
        WR_CONTACT
    } wr_op_t;

    // Controller to datapath
    typedef struct packed {
        logic               latch_in;
        wr_op_t             wr_op;
        logic               count_inc;
        logic               out_peer;
        logic               out_status;
        logic [CODE_W-1:0]  code;
    } xdl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic               out_free;
        logic               dist_eq;
        logic               dist_gt;
        logic               is_self;
        logic               pick_new;
        logic               is_resp;
        logic               oq_full;
        logic [CMD_W-1:0]   command;
        logic [MAXC_W-1:0]  sel_limit;
    } xdl_stat_t;

endpackage

// File: rtl/xor_distance_lookup_candidate_table.sv
// ----------------------------------------------------------------------------
// XOR distance lookup candidate table
// Shortlist of peers for one lookup, sorted by XOR distance from the target
// key, with add, mark and select requests and a closing status item.
//
//   Channel   Signals                                         Direction
//   input     in_valid/in_stall, command, peer_id, ...        into block
//   output    out_valid/out_stall, kind, out_peer_id, ...     out of block
//   config    cfg_we, cfg_index, cfg_data                     into block
//
// After it is accepted, a request passes through a dispatch state, then walks
// the table entry by entry. An add walks up to the insertion point, shifts the
// entries above it one a cycle through the single write port of the entry
// memory, then writes the new entry and issues the status item. Selects walk
// the table, holding on an entry while the output is stalled, then issue the
// status item.
// Reset empties the table at once; no clearing pass is needed.
// The next request is taken once the status item is in the output register.
// ----------------------------------------------------------------------------
module xor_distance_lookup_candidate_table #(
    parameter int CAPACITY = 32,
    parameter int ID_BITS  = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [xdl_pkg::CFGI_W-1:0]  cfg_index,
    input  logic [xdl_pkg::KEY_W-1:0]   cfg_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [xdl_pkg::CMD_W-1:0]   command,
    input  logic [xdl_pkg::KEY_W-1:0]   peer_id,
    input  logic [xdl_pkg::EP_W-1:0]    peer_endpoint,
    input  logic [xdl_pkg::MAXC_W-1:0]  sel_limit,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        kind,
    output logic [xdl_pkg::KEY_W-1:0]   out_peer_id,
    output logic [xdl_pkg::EP_W-1:0]    out_endpoint,
    output logic                        last,
    output logic [xdl_pkg::CODE_W-1:0]  status_code,
    output logic                        any_responded,
    output logic                        all_completed,
    output logic [xdl_pkg::MAXC_W-1:0]  in_flight
);
    import xdl_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    xdl_cmd_t       cmd;
    xdl_stat_t      stat;
    logic [AW-1:0]  rd_addr;
    logic [AW-1:0]  wr_addr;
    logic [CW-1:0]  entry_count;

    // Request sequencer
    xdl_ctrl #(
        .CAPACITY (CAPACITY),
        .AW       (AW),
        .CW       (CW)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .stat        (stat),
        .entry_count (entry_count),
        .cmd         (cmd),
        .rd_addr     (rd_addr),
        .wr_addr     (wr_addr)
    );

    // Table, counters and output register
    xdl_datapath #(
        .CAPACITY (CAPACITY),
        .ID_BITS  (ID_BITS),
        .AW       (AW),
        .CW       (CW)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .command       (command),
        .peer_id       (peer_id),
        .peer_endpoint (peer_endpoint),
        .sel_limit     (sel_limit),
        .cmd           (cmd),
        .rd_addr       (rd_addr),
        .wr_addr       (wr_addr),
        .stat          (stat),
        .entry_count   (entry_count),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .kind          (kind),
        .out_peer_id   (out_peer_id),
        .out_endpoint  (out_endpoint),
        .last          (last),
        .status_code   (status_code),
        .any_responded (any_responded),
        .all_completed (all_completed),
        .in_flight     (in_flight)
    );

endmodule

// File: rtl/xdl_datapath.sv
// ----------------------------------------------------------------------------
// XOR distance shortlist datapath
// Holds the entry memory, configuration, counters, the latched request and
// the output register, and reports compare results to the controller.
// ----------------------------------------------------------------------------
module xdl_datapath #(
    parameter int CAPACITY = 32,
    parameter int ID_BITS  = 64,
    parameter int AW       = 5,
    parameter int CW       = 6
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [xdl_pkg::CFGI_W-1:0]  cfg_index,
    input  logic [xdl_pkg::KEY_W-1:0]   cfg_data,
    input  logic [xdl_pkg::CMD_W-1:0]   command,
    input  logic [xdl_pkg::KEY_W-1:0]   peer_id,
    input  logic [xdl_pkg::EP_W-1:0]    peer_endpoint,
    input  logic [xdl_pkg::MAXC_W-1:0]  sel_limit,
    input  xdl_pkg::xdl_cmd_t           cmd,
    input  logic [AW-1:0]               rd_addr,
    input  logic [AW-1:0]               wr_addr,
    output xdl_pkg::xdl_stat_t          stat,
    output logic [CW-1:0]               entry_count,
    input  logic                        out_stall,
    output logic                        out_valid,
    output logic                        kind,
    output logic [xdl_pkg::KEY_W-1:0]   out_peer_id,
    output logic [xdl_pkg::EP_W-1:0]    out_endpoint,
    output logic                        last,
    output logic [xdl_pkg::CODE_W-1:0]  status_code,
    output logic                        any_responded,
    output logic                        all_completed,
    output logic [xdl_pkg::MAXC_W-1:0]  in_flight
);
    import xdl_pkg::*;

    localparam int MW     = ID_BITS + EP_W + PH_W + ATT_W;
    localparam int PH_LO  = ATT_W;
    localparam int EP_LO  = ATT_W + PH_W;
    localparam int DST_LO = ATT_W + PH_W + EP_W;

    // Entry memory: {distance, endpoint, phase, attempts}
    logic [MW-1:0] mem [CAPACITY];
    logic [MW-1:0] rdata_reg;

    logic [KEY_W-1:0]   target_reg;
    logic [EP_W-1:0]    self_reg;
    logic [ATT_W-1:0]   max_att_reg;
    logic [ID_BITS-1:0] d_reg;
    logic [EP_W-1:0]    ep_reg;
    logic [CMD_W-1:0]   command_reg;
    logic [MAXC_W-1:0]  maxc_reg;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      resp_reg;
    logic [MAXC_W-1:0]  outst_reg;

    logic                out_valid_reg;
    logic                kind_reg;
    logic [KEY_W-1:0]    id_reg;
    logic [EP_W-1:0]     oep_reg;
    logic                last_reg;
    logic [CODE_W-1:0]   code_reg;
    logic                anyr_reg;
    logic                allc_reg;
    logic [MAXC_W-1:0]   infl_reg;

    logic [ID_BITS-1:0] rd_dist;
    logic [EP_W-1:0]    rd_ep;
    logic [PH_W-1:0]    rd_ph;
    logic [ATT_W-1:0]   rd_att;
    logic [ATT_W-1:0]   att_sat;
    logic [MW-1:0]      wdata;
    logic               we;
    logic               out_free;

    // Fields of the entry just read
    assign rd_dist = rdata_reg[DST_LO +: ID_BITS];
    assign rd_ep   = rdata_reg[EP_LO +: EP_W];
    assign rd_ph   = rdata_reg[PH_LO +: PH_W];
    assign rd_att  = rdata_reg[0 +: ATT_W];
    assign att_sat = (rd_att == ATT_MAX) ? rd_att : rd_att + ATT_W'(1);

    assign out_free = !out_valid_reg || !out_stall;

    // Status towards the controller
    always_comb
    begin
        stat.out_free  = out_free;
        stat.dist_eq   = rd_dist == d_reg;
        stat.dist_gt   = rd_dist > d_reg;
        stat.is_self   = rd_ep == self_reg;
        stat.pick_new  = (rd_ph == PH_UNKNOWN) ||
                         ((rd_ph == PH_TIMEDOUT) && (rd_att < max_att_reg));
        stat.is_resp   = rd_ph == PH_RESPONDED;
        stat.oq_full   = outst_reg >= maxc_reg;
        stat.command   = command_reg;
        stat.sel_limit = maxc_reg;
    end

    // Write data selection
    always_comb
    begin
        we    = 1'b1;
        wdata = rdata_reg;
        case (cmd.wr_op)
            WR_INSERT:  wdata = {d_reg, ep_reg, PH_UNKNOWN, ATT_W'(0)};
            WR_SHIFT:   wdata = rdata_reg;
            WR_RESP:    wdata = {rd_dist, rd_ep, PH_RESPONDED, ATT_W'(0)};
            WR_TIMEOUT: wdata = {rd_dist, rd_ep, PH_TIMEDOUT, att_sat};
            WR_CONTACT: wdata = {rd_dist, rd_ep, PH_CONTACTED, rd_att};
            default:    we = 1'b0;
        endcase
    end

    // Memory with registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wdata;
        end
        rdata_reg <= mem[rd_addr];
    end

    // Latched request fields
    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            d_reg       <= peer_id[ID_BITS-1:0] ^ target_reg[ID_BITS-1:0];
            ep_reg      <= peer_endpoint;
            command_reg <= command;
            maxc_reg    <= sel_limit;
        end
    end

    // Configuration and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg  <= '0;
            self_reg    <= '0;
            max_att_reg <= ATT_RESET_VAL;
            count_reg   <= '0;
            resp_reg    <= '0;
            outst_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_TARGET:  target_reg  <= cfg_data;
                    CFG_SELF:    self_reg    <= cfg_data[EP_W-1:0];
                    CFG_MAX_ATT: max_att_reg <= cfg_data[ATT_W-1:0];
                    default:     ;
                endcase
            end
            if (cmd.count_inc)
            begin
                count_reg <= count_reg + CW'(1);
            end
            case (cmd.wr_op)
                WR_RESP:
                begin
                    if (rd_ph != PH_RESPONDED)
                    begin
                        resp_reg <= resp_reg + CW'(1);
                    end
                    if (outst_reg != '0)
                    begin
                        outst_reg <= outst_reg - MAXC_W'(1);
                    end
                end
                WR_TIMEOUT:
                begin
                    if (rd_ph == PH_RESPONDED)
                    begin
                        resp_reg <= resp_reg - CW'(1);
                    end
                    if (outst_reg != '0)
                    begin
                        outst_reg <= outst_reg - MAXC_W'(1);
                    end
                end
                WR_CONTACT: outst_reg <= outst_reg + MAXC_W'(1);
                default:    ;
            endcase
        end
    end

    // Output register: valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_peer || cmd.out_status)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register: payload
    always_ff @(posedge clk)
    begin
        if (cmd.out_peer)
        begin
            kind_reg <= 1'b0;
            id_reg   <= KEY_W'(rd_dist ^ target_reg[ID_BITS-1:0]);
            oep_reg  <= rd_ep;
            last_reg <= 1'b0;
            code_reg <= ST_OK;
            anyr_reg <= 1'b0;
            allc_reg <= 1'b0;
            infl_reg <= '0;
        end
        else if (cmd.out_status)
        begin
            kind_reg <= 1'b1;
            id_reg   <= '0;
            oep_reg  <= '0;
            last_reg <= 1'b1;
            code_reg <= cmd.code;
            anyr_reg <= resp_reg != '0;
            allc_reg <= outst_reg == '0;
            infl_reg <= outst_reg;
        end
    end

    assign entry_count   = count_reg;
    assign out_valid     = out_valid_reg;
    assign kind          = kind_reg;
    assign out_peer_id   = id_reg;
    assign out_endpoint  = oep_reg;
    assign last          = last_reg;
    assign status_code   = code_reg;
    assign any_responded = anyr_reg;
    assign all_completed = allc_reg;
    assign in_flight     = infl_reg;

    // The table never grows past its capacity.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("entry count exceeds capacity");

    // Responded entries are a subset of the stored entries.
    a_resp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        resp_reg <= count_reg)
        else $error("responded count exceeds entry count");

    // A result is only loaded when the output register can take it.
    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.out_peer || cmd.out_status) |-> out_free)
        else $error("result loaded over a waiting result");

    // Table writes stay within the stored entries plus one new slot.
    a_wr_addr: assert property (@(posedge clk) disable iff (!rst_n)
        we |-> (CW'(wr_addr) <= count_reg))
        else $error("write beyond the end of the table");

endmodule

// File: rtl/xdl_ctrl.sv
// ----------------------------------------------------------------------------
// XOR distance shortlist controller
// Sequences each request: table walk, sorted insert shift, peer emission and
// the closing status item.
// ----------------------------------------------------------------------------
module xdl_ctrl #(
    parameter int CAPACITY = 32,
    parameter int AW       = 5,
    parameter int CW       = 6
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  xdl_pkg::xdl_stat_t  stat,
    input  logic [CW-1:0]       entry_count,
    output xdl_pkg::xdl_cmd_t   cmd,
    output logic [AW-1:0]       rd_addr,
    output logic [AW-1:0]       wr_addr
);
    import xdl_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_SHIFT,
        S_PUT,
        S_STATUS
    } state_t;

    state_t             state_reg, state_next;
    logic [AW-1:0]      eval_reg, eval_next;
    logic [AW-1:0]      pos_reg, pos_next;
    logic [MAXC_W-1:0]  n_reg, n_next;
    logic [CODE_W-1:0]  code_reg, code_next;

    logic               last_entry;
    logic               full;
    logic [AW-1:0]      adv_addr;

    assign last_entry = (CW'(eval_reg) + CW'(1)) >= entry_count;
    assign full       = entry_count >= CW'(CAPACITY);
    assign adv_addr   = eval_reg + AW'(1);
    assign in_stall   = state_reg != S_IDLE;

    // Next state and commands
    always_comb
    begin
        state_next    = state_reg;
        eval_next     = eval_reg;
        pos_next      = pos_reg;
        n_next        = n_reg;
        code_next     = code_reg;
        rd_addr       = eval_reg;
        wr_addr       = eval_reg;
        cmd           = '0;
        cmd.wr_op     = WR_NONE;
        cmd.code      = code_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                rd_addr = '0;
                if (in_valid)
                begin
                    cmd.latch_in = 1'b1;
                    eval_next    = '0;
                    n_next       = '0;
                    code_next    = ST_OK;
                    state_next   = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                rd_addr = '0;
                case (stat.command) inside
                    CMD_ADD:
                    begin
                        if (entry_count == '0)
                        begin
                            pos_next   = '0;
                            state_next = S_PUT;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                    CMD_MARK_RESP, CMD_MARK_TO:
                    begin
                        if (entry_count == '0)
                        begin
                            code_next  = ST_NOT_FOUND;
                            state_next = S_STATUS;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                    CMD_SEL_NEW, CMD_SEL_RESP:
                    begin
                        state_next = (entry_count == '0) ? S_STATUS : S_SCAN;
                    end
                    default: state_next = S_STATUS;
                endcase
            end
            S_SCAN:
            begin
                case (stat.command) inside
                    CMD_ADD:
                    begin
                        if (stat.dist_eq)
                        begin
                            code_next  = ST_DUP;
                            state_next = S_STATUS;
                        end
                        else if (stat.dist_gt || last_entry)
                        begin
                            if (full)
                            begin
                                code_next  = ST_FULL;
                                state_next = S_STATUS;
                            end
                            else if (stat.dist_gt)
                            begin
                                // Start the shift from the last stored entry.
                                pos_next   = eval_reg;
                                rd_addr    = AW'(entry_count - CW'(1));
                                eval_next  = AW'(entry_count - CW'(1));
                                state_next = S_SHIFT;
                            end
                            else
                            begin
                                pos_next   = AW'(entry_count);
                                state_next = S_PUT;
                            end
                        end
                        else
                        begin
                            rd_addr   = adv_addr;
                            eval_next = adv_addr;
                        end
                    end
                    CMD_MARK_RESP, CMD_MARK_TO:
                    begin
                        if (stat.dist_eq)
                        begin
                            cmd.wr_op  = (stat.command == CMD_MARK_RESP) ?
                                         WR_RESP : WR_TIMEOUT;
                            state_next = S_STATUS;
                        end
                        else if (last_entry)
                        begin
                            code_next  = ST_NOT_FOUND;
                            state_next = S_STATUS;
                        end
                        else
                        begin
                            rd_addr   = adv_addr;
                            eval_next = adv_addr;
                        end
                    end
                    CMD_SEL_NEW:
                    begin
                        if (stat.oq_full)
                        begin
                            state_next = S_STATUS;
                        end
                        else if (!stat.is_self && stat.pick_new)
                        begin
                            // Holds and re-reads the entry while the output waits.
                            if (stat.out_free)
                            begin
                                cmd.wr_op    = WR_CONTACT;
                                cmd.out_peer = 1'b1;
                                if (last_entry)
                                begin
                                    state_next = S_STATUS;
                                end
                                else
                                begin
                                    rd_addr   = adv_addr;
                                    eval_next = adv_addr;
                                end
                            end
                        end
                        else if (last_entry)
                        begin
                            state_next = S_STATUS;
                        end
                        else
                        begin
                            rd_addr   = adv_addr;
                            eval_next = adv_addr;
                        end
                    end
                    CMD_SEL_RESP:
                    begin
                        if (n_reg >= stat.sel_limit)
                        begin
                            state_next = S_STATUS;
                        end
                        else if (stat.is_resp)
                        begin
                            if (stat.out_free)
                            begin
                                cmd.out_peer = 1'b1;
                                n_next       = n_reg + MAXC_W'(1);
                                if (last_entry)
                                begin
                                    state_next = S_STATUS;
                                end
                                else
                                begin
                                    rd_addr   = adv_addr;
                                    eval_next = adv_addr;
                                end
                            end
                        end
                        else if (last_entry)
                        begin
                            state_next = S_STATUS;
                        end
                        else
                        begin
                            rd_addr   = adv_addr;
                            eval_next = adv_addr;
                        end
                    end
                    default: state_next = S_STATUS;
                endcase
            end
            S_SHIFT:
            begin
                // Move one entry up per cycle, reading the next one down.
                cmd.wr_op = WR_SHIFT;
                wr_addr   = adv_addr;
                if (eval_reg == pos_reg)
                begin
                    state_next = S_PUT;
                end
                else
                begin
                    rd_addr   = eval_reg - AW'(1);
                    eval_next = eval_reg - AW'(1);
                end
            end
            S_PUT:
            begin
                cmd.wr_op     = WR_INSERT;
                cmd.count_inc = 1'b1;
                wr_addr       = pos_reg;
                state_next    = S_STATUS;
            end
            S_STATUS:
            begin
                if (stat.out_free)
                begin
                    cmd.out_status = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // State and sequencing registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            eval_reg  <= '0;
            pos_reg   <= '0;
            n_reg     <= '0;
            code_reg  <= ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            eval_reg  <= eval_next;
            pos_reg   <= pos_next;
            n_reg     <= n_next;
            code_reg  <= code_next;
        end
    end

    // The shift never runs below the insertion point.
    a_shift_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT) |-> (eval_reg >= pos_reg))
        else $error("shift pointer below insertion point");

    // Every request ends by passing through the status state.
    a_status_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE && state_next == S_IDLE) |-> cmd.out_status)
        else $error("request closed without a status item");

    // Peers are only emitted while walking the table.
    a_peer_scan: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_peer |-> (state_reg == S_SCAN))
        else $error("peer emitted outside the walk");

endmodule

// File: tb/sv/xdl_checker.sv
// ----------------------------------------------------------------------------
// XOR distance shortlist checker
// Watches the request and result channels, predicts the results of every
// accepted request from its own copy of the table and compares them in order.
// ----------------------------------------------------------------------------
module xdl_checker
    import xdl_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [CFGI_W-1:0]   cfg_index,
    input  logic [KEY_W-1:0]    cfg_data,
    input  logic                in_valid,
    input  logic                in_stall,
    input  logic [CMD_W-1:0]    command,
    input  logic [KEY_W-1:0]    peer_id,
    input  logic [EP_W-1:0]     peer_endpoint,
    input  logic [MAXC_W-1:0]   sel_limit,
    input  logic                out_valid,
    input  logic                out_stall,
    input  logic                kind,
    input  logic [KEY_W-1:0]    out_peer_id,
    input  logic [EP_W-1:0]     out_endpoint,
    input  logic                last,
    input  logic [CODE_W-1:0]   status_code,
    input  logic                any_responded,
    input  logic                all_completed,
    input  logic [MAXC_W-1:0]   in_flight,
    output int                  fail_count,
    output int                  pending
);

    localparam int DEPTH = 32;

    typedef struct packed {
        logic               kind;
        logic [KEY_W-1:0]   id;
        logic [EP_W-1:0]    ep;
        logic               last;
        logic [CODE_W-1:0]  code;
        logic               anyr;
        logic               done;
        logic [MAXC_W-1:0]  inflight;
    } result_t;

    // Model state of the shortlist.
    logic [KEY_W-1:0]  key_q;
    logic [EP_W-1:0]   self_q;
    logic [ATT_W-1:0]  att_limit;
    logic [KEY_W-1:0]  dist_m [DEPTH];
    logic [EP_W-1:0]   ep_m   [DEPTH];
    logic [PH_W-1:0]   ph_m   [DEPTH];
    logic [ATT_W-1:0]  att_m  [DEPTH];
    int                count_m;
    int                busy_m;
    result_t           expected_results [$];

    assign pending = expected_results.size();

    function automatic int find_dist(logic [KEY_W-1:0] d);
        for (int i = 0; i < count_m; i++)
            if (dist_m[i] == d)
                return i;
        return -1;
    endfunction

    function automatic result_t peer_result(int i);
        result_t r;
        r = '0;
        r.id = dist_m[i] ^ key_q;
        r.ep = ep_m[i];
        return r;
    endfunction

    // Appends one expected result at the tail of the queue.
    task automatic expect_result(result_t r);
        expected_results.insert(expected_results.size(), r);
    endtask

    // Works out the results of one request and updates the model table.
    task automatic predict_request(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] id,
                                   logic [EP_W-1:0] ep, logic [MAXC_W-1:0] maxc);
        logic [KEY_W-1:0] d;
        logic [CODE_W-1:0] code;
        int pos;
        int n;
        result_t r;
        d = id ^ key_q;
        code = ST_OK;
        n = 0;
        if (cmd == CMD_ADD) begin
            if (find_dist(d) >= 0)
                code = ST_DUP;
            else if (count_m >= DEPTH)
                code = ST_FULL;
            else
            begin
                pos = 0;
                while (pos < count_m && dist_m[pos] < d)
                    pos++;
                for (int i = count_m; i > pos; i--)
                begin
                    dist_m[i] = dist_m[i-1];
                    ep_m[i] = ep_m[i-1];
                    ph_m[i] = ph_m[i-1];
                    att_m[i] = att_m[i-1];
                end
                dist_m[pos] = d;
                ep_m[pos] = ep;
                ph_m[pos] = PH_UNKNOWN;
                att_m[pos] = '0;
                count_m++;
            end
        end
        else if (cmd == CMD_MARK_RESP || cmd == CMD_MARK_TO)
        begin
            pos = find_dist(d);
            if (pos < 0)
                code = ST_NOT_FOUND;
            else
            begin
                if (busy_m > 0)
                    busy_m--;
                if (cmd == CMD_MARK_RESP)
                begin
                    att_m[pos] = '0;
                    ph_m[pos] = PH_RESPONDED;
                end
                else
                begin
                    if (att_m[pos] < ATT_MAX)
                        att_m[pos]++;
                    ph_m[pos] = PH_TIMEDOUT;
                end
            end
        end
        else if (cmd == CMD_SEL_NEW)
        begin
            for (int i = 0; i < count_m && busy_m < maxc; i++)
            begin
                if (ep_m[i] != self_q && (ph_m[i] == PH_UNKNOWN ||
                    (ph_m[i] == PH_TIMEDOUT && att_m[i] < att_limit)))
                begin
                    ph_m[i] = PH_CONTACTED;
                    busy_m++;
                    expect_result(peer_result(i));
                end
            end
        end
        else if (cmd == CMD_SEL_RESP)
        begin
            for (int i = 0; i < count_m && n < maxc; i++)
            begin
                if (ph_m[i] == PH_RESPONDED)
                begin
                    expect_result(peer_result(i));
                    n++;
                end
            end
        end
        // Closing status item.
        r = '0;
        r.kind = 1'b1;
        r.last = 1'b1;
        r.code = code;
        for (int i = 0; i < count_m; i++)
            if (ph_m[i] == PH_RESPONDED)
                r.anyr = 1'b1;
        r.done = (busy_m == 0);
        r.inflight = busy_m[MAXC_W-1:0];
        expect_result(r);
    endtask

    // Compares one field and counts a mismatch.
    task automatic check_field(string name, logic [KEY_W-1:0] exp_v,
                               logic [KEY_W-1:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t e;
        if (!rst_n)
        begin
            key_q <= '0;
            self_q <= '0;
            att_limit <= ATT_RESET_VAL;
            count_m = 0;
            busy_m = 0;
            fail_count = 0;
            expected_results.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_TARGET:  key_q <= cfg_data;
                    CFG_SELF:    self_q <= cfg_data[EP_W-1:0];
                    CFG_MAX_ATT: att_limit <= cfg_data[ATT_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                predict_request(command, peer_id, peer_endpoint, sel_limit);
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result with no expectation waiting");
                    fail_count++;
                end
                else
                begin
                    e = expected_results.pop_front();
                    check_field("kind", KEY_W'(e.kind), KEY_W'(kind));
                    check_field("out_peer_id", e.id, out_peer_id);
                    check_field("out_endpoint", KEY_W'(e.ep), KEY_W'(out_endpoint));
                    check_field("last", KEY_W'(e.last), KEY_W'(last));
                    check_field("status_code", KEY_W'(e.code), KEY_W'(status_code));
                    check_field("any_responded", KEY_W'(e.anyr),
                                KEY_W'(any_responded));
                    check_field("all_completed", KEY_W'(e.done),
                                KEY_W'(all_completed));
                    check_field("in_flight", KEY_W'(e.inflight), KEY_W'(in_flight));
                end
            end
        end
    end

endmodule

// File: tb/sv/xor_distance_lookup_candidate_table_tb.sv
// ----------------------------------------------------------------------------
// XOR distance lookup candidate table testbench
// Drives directed and random lookup requests with random gaps and stalls
// across several register settings; the checker predicts and compares.
// ----------------------------------------------------------------------------
module xor_distance_lookup_candidate_table_tb;
    import xdl_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [CFGI_W-1:0]  cfg_index = '0;
    logic [KEY_W-1:0]   cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [CMD_W-1:0]   command = '0;
    logic [KEY_W-1:0]   peer_id = '0;
    logic [EP_W-1:0]    peer_endpoint = '0;
    logic [MAXC_W-1:0]  sel_limit = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic               kind;
    logic [KEY_W-1:0]   out_peer_id;
    logic [EP_W-1:0]    out_endpoint;
    logic               last;
    logic [CODE_W-1:0]  status_code;
    logic               any_responded;
    logic               all_completed;
    logic [MAXC_W-1:0]  in_flight;
    int                 fail_count;
    int                 pending;
    int                 idle_cycles = 0;

    // Identifiers already added, so that marks and duplicates hit real peers.
    logic [KEY_W-1:0]   known_ids [$];
    logic [EP_W-1:0]    self_ep = '0;

    always #2 clk = ~clk;

    xor_distance_lookup_candidate_table DUT (.*);

    xdl_checker u_checker (.*);

    // Watchdog on cycles with no accepted request or result.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL xor_distance_lookup_candidate_table");
            $finish;
        end
    end

    // Result side stalls for a random number of cycles per result.
    initial
    begin
        int gap;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
                if (gap > 0)
                begin
                    out_stall <= 1'b1;
                    repeat (gap) @(posedge clk);
                    out_stall <= 1'b0;
                end
            end
        end
    end

    // One register write; the enable drops for a cycle before the next one.
    task automatic write_reg(logic [CFGI_W-1:0] idx, logic [KEY_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Stops sending and waits until every expected result has arrived,
    // plus a settling margin.
    task automatic drain;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic send_request(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] id,
                                logic [EP_W-1:0] ep, logic [MAXC_W-1:0] maxc,
                                bit random_gap);
        int gap;
        gap = random_gap ? $urandom_range(0, 6) : 0;
        if ($urandom_range(0, 4) == 0)
            gap = 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        command <= cmd;
        peer_id <= id;
        peer_endpoint <= ep;
        sel_limit <= maxc;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (cmd == CMD_ADD)
            known_ids.insert(known_ids.size(), id);
    endtask

    function automatic logic [KEY_W-1:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [EP_W-1:0] rand_ep();
        if ($urandom_range(0, 9) == 0)
            return self_ep;
        return EP_W'({$urandom(), $urandom()});
    endfunction

    // One random request, mostly well formed against the known peers.
    task automatic random_request;
        int sel;
        logic [KEY_W-1:0] id;
        logic [MAXC_W-1:0] maxc;
        sel = $urandom_range(0, 99);
        id = (known_ids.size() > 0 && $urandom_range(0, 4) != 0)
             ? known_ids[$urandom_range(0, known_ids.size() - 1)] : rand64();
        maxc = ($urandom_range(0, 7) == 0) ? MAXC_W'($urandom_range(0, 63))
                                            : MAXC_W'($urandom_range(0, 32));
        if (sel < 30)
            send_request(CMD_ADD, ($urandom_range(0, 5) == 0) ? id : rand64(),
                         rand_ep(), maxc, 1'b1);
        else if (sel < 50)
            send_request(CMD_MARK_RESP, id, rand_ep(), maxc, 1'b1);
        else if (sel < 70)
            send_request(CMD_MARK_TO, id, rand_ep(), maxc, 1'b1);
        else if (sel < 85)
            send_request(CMD_SEL_NEW, id, rand_ep(), maxc, 1'b1);
        else if (sel < 97)
            send_request(CMD_SEL_RESP, id, rand_ep(), maxc, 1'b1);
        else
            send_request(CMD_W'($urandom_range(5, 7)), rand64(), rand_ep(), maxc,
                         1'b1);
    endtask

    // Stimulus and verdict.
    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part on reset settings: empty table cases first.
        send_request(CMD_MARK_RESP, '0, '0, 6'd1, 1'b0);
        send_request(CMD_SEL_NEW, '0, '0, 6'd32, 1'b0);
        send_request(CMD_ADD, '0, '0, 6'd0, 1'b0);
        send_request(CMD_ADD, '1, '1, 6'd63, 1'b0);
        send_request(CMD_ADD, '1, 48'h1, 6'd0, 1'b0);
        send_request(CMD_ADD, 64'h5555_aaaa_0f0f_f0f0, 48'h0123_4567_89ab, 6'd0, 1'b0);
        send_request(CMD_SEL_NEW, '0, '0, 6'd0, 1'b0);
        send_request(CMD_SEL_NEW, '0, '0, 6'd2, 1'b0);
        send_request(CMD_MARK_RESP, '1, '0, 6'd0, 1'b0);
        send_request(CMD_MARK_RESP, '1, '0, 6'd0, 1'b0);
        send_request(CMD_MARK_TO, 64'h5555_aaaa_0f0f_f0f0, '0, 6'd0, 1'b0);
        send_request(CMD_SEL_RESP, '0, '0, 6'd32, 1'b0);
        send_request(CMD_SEL_RESP, '0, '0, 6'd0, 1'b0);
        send_request(CMD_MARK_TO, 64'h1234, '0, 6'd0, 1'b0);
        send_request(3'd5, '1, '1, 6'd63, 1'b0);
        send_request(3'd7, '0, '0, 6'd0, 1'b0);
        for (int i = 0; i < 17; i++)
            send_request(CMD_MARK_TO, '1, '0, 6'd0, 1'b0);
        send_request(CMD_SEL_NEW, '0, '0, 6'd32, 1'b0);
        drain();

        // Key change after adds, new own endpoint and retry limit extremes.
        write_reg(CFG_TARGET, '1);
        self_ep = 48'h0123_4567_89ab;
        write_reg(CFG_SELF, {16'h0, self_ep});
        write_reg(CFG_MAX_ATT, 64'd15);
        send_request(CMD_SEL_RESP, '0, '0, 6'd32, 1'b0);
        send_request(CMD_SEL_NEW, '0, '0, 6'd32, 1'b0);
        for (int i = 0; i < 34; i++)
            send_request(CMD_ADD, rand64(), rand_ep(), 6'd0, 1'b0);
        drain();

        // Random phases, each with a fresh table setting.
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: write_reg(CFG_MAX_ATT, 64'd1);
                1: write_reg(CFG_TARGET, '0);
                2: write_reg(CFG_MAX_ATT, 64'($urandom_range(1, 15)));
                3: write_reg(CFG_TARGET, rand64());
                default: write_reg(CFG_SELF, '1);
            endcase
            if (ph == 4)
                self_ep = '1;
            for (int i = 0; i < 56; i++)
            begin
                random_request();
                if (i == 28)
                begin
                    in_valid <= 1'b0;
                    @(posedge clk);
                    while (pending != 0)
                        @(posedge clk);
                end
            end
            drain();
        end
        drain();

        if (fail_count == 0)
            $display("PASS xor_distance_lookup_candidate_table");
        else
            $display("FAIL xor_distance_lookup_candidate_table");
        $finish;
    end

endmodule
